@@ rtl/ksts_pkg.sv @@
// constants and types for the trimmed-suffix k-th smallest select block
// no dependencies; used by kth_smallest_trimmed_select_top
package ksts_pkg;

  localparam int MAX_STRINGS = 128;
  localparam int MAX_DIGITS  = 32;

  // field widths fixed by the block interface
  localparam int DIGIT_W  = 4;
  localparam int SIDX_W   = 7;
  localparam int DPOS_W   = 5;
  localparam int RANK_W   = 8;
  localparam int TRIM_W   = 6;
  localparam int SCOUNT_W = 8;
  localparam int SLEN_W   = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // derived storage widths
  localparam int DEPTH  = MAX_STRINGS * MAX_DIGITS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(MAX_STRINGS + 1);
  localparam int LEN_W  = $clog2(MAX_DIGITS + 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STRING_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRING_LENGTH = 1'b1;

  // request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAIR,
    ST_READ,
    ST_CMP,
    ST_RANK
  } state_t;

endpackage

@@ rtl/kth_smallest_trimmed_select_top.sv @@
// kth_smallest_trimmed_select_top: digit string store and rank-counting query sequencer
// depends on ksts_pkg
// load: busy stays low. bad query: result strobed on done in the cycle after start.
// valid query: for each string i, the sequencer compares i digit by digit with each other
// string over the trimmed suffix; busy is high for the scan and done is raised as busy drops.
// it uses the two-read-port digit memory and the single digit comparator.
// reset (rst, synchronous): sequencer idle, string_count and string_length back to 1;
// the digit store is not cleared. results cannot be held off by the receiver.
module kth_smallest_trimmed_select_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            req_type,
  input  logic [ksts_pkg::SIDX_W-1:0]     string_index,
  input  logic [ksts_pkg::DPOS_W-1:0]     digit_position,
  input  logic [ksts_pkg::DIGIT_W-1:0]    digit_value,
  input  logic [ksts_pkg::RANK_W-1:0]     rank_k,
  input  logic [ksts_pkg::TRIM_W-1:0]     trim_length,
  output logic                            done,
  output logic [ksts_pkg::SIDX_W-1:0]     answer_index,
  output logic                            query_error,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ksts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ksts_pkg::CFG_DATA_W-1:0] cfg_data
);

  ksts_pkg::state_t state, state_next;

  logic [ksts_pkg::SCOUNT_W-1:0] string_count;
  logic [ksts_pkg::SLEN_W-1:0]   string_length;

  logic [ksts_pkg::CNT_W-1:0]  used_count;
  logic [ksts_pkg::LEN_W-1:0]  used_len;

  logic [ksts_pkg::CNT_W-1:0]  i_cnt, i_cnt_next;
  logic [ksts_pkg::CNT_W-1:0]  j_cnt, j_cnt_next;
  logic [ksts_pkg::CNT_W-1:0]  ahead_cnt, ahead_cnt_next;
  logic [ksts_pkg::LEN_W-1:0]  pos, pos_next;
  logic [ksts_pkg::LEN_W-1:0]  first_pos, first_pos_next;
  logic [ksts_pkg::RANK_W-1:0] rank, rank_next;

  logic                          done_next;
  logic [ksts_pkg::SIDX_W-1:0]   answer_index_next;
  logic                          query_error_next;

  logic [ksts_pkg::DIGIT_W-1:0] digit_store [ksts_pkg::DEPTH];
  logic [ksts_pkg::DIGIT_W-1:0] rd_j, rd_i;
  logic [ksts_pkg::ADDR_W-1:0]  wr_addr, rd_addr_j, rd_addr_i;

  logic accept, load_accept, query_accept, load_in_range, query_bad, load_wr;
  logic last_digit, digits_differ, j_before_i, rank_hit, last_string;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ksts_pkg::ST_IDLE);

  assign accept       = start && !busy;
  assign load_accept  = accept && (req_type == ksts_pkg::REQ_LOAD);
  assign query_accept = accept && (req_type == ksts_pkg::REQ_QUERY);

  // register values above the store size act as the store size
  assign used_count = ksts_pkg::CNT_W'((32'(string_count) > ksts_pkg::MAX_STRINGS) ?
                      ksts_pkg::MAX_STRINGS : 32'(string_count));
  assign used_len   = ksts_pkg::LEN_W'((32'(string_length) > ksts_pkg::MAX_DIGITS) ?
                      ksts_pkg::MAX_DIGITS : 32'(string_length));

  assign load_in_range = (32'(string_index) < ksts_pkg::MAX_STRINGS) &&
                         (32'(digit_position) < ksts_pkg::MAX_DIGITS);
  assign load_wr       = load_accept && load_in_range;

  assign query_bad = (rank_k == '0) || (32'(rank_k) > 32'(used_count)) ||
                     (trim_length == '0) || (32'(trim_length) > 32'(used_len));

  assign wr_addr   = ksts_pkg::ADDR_W'(32'(string_index) * ksts_pkg::MAX_DIGITS +
                     32'(digit_position));
  assign rd_addr_j = ksts_pkg::ADDR_W'(32'(j_cnt) * ksts_pkg::MAX_DIGITS + 32'(pos));
  assign rd_addr_i = ksts_pkg::ADDR_W'(32'(i_cnt) * ksts_pkg::MAX_DIGITS + 32'(pos));

  // the shared digit comparator
  assign digits_differ = (rd_j != rd_i);
  assign last_digit    = (32'(pos) == 32'(used_len) - 32'd1);
  assign j_before_i    = digits_differ ? (rd_j < rd_i) : (j_cnt < i_cnt);

  assign rank_hit    = (32'(ahead_cnt) == 32'(rank) - 32'd1);
  assign last_string = (32'(i_cnt) + 32'd1 >= 32'(used_count));

  always_ff @(posedge clk) begin
    if (load_wr) begin
      digit_store[wr_addr] <= digit_value;
    end
    rd_j <= digit_store[rd_addr_j];
    rd_i <= digit_store[rd_addr_i];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ksts_pkg::ST_IDLE: begin
        if (query_accept && !query_bad) begin
          state_next = ksts_pkg::ST_PAIR;
        end
      end
      ksts_pkg::ST_PAIR: begin
        if (j_cnt == used_count) begin
          state_next = ksts_pkg::ST_RANK;
        end else if (j_cnt != i_cnt) begin
          state_next = ksts_pkg::ST_READ;
        end
      end
      ksts_pkg::ST_READ: state_next = ksts_pkg::ST_CMP;
      ksts_pkg::ST_CMP: begin
        if (digits_differ || last_digit) begin
          state_next = ksts_pkg::ST_PAIR;
        end else begin
          state_next = ksts_pkg::ST_READ;
        end
      end
      ksts_pkg::ST_RANK: begin
        if (rank_hit || last_string) begin
          state_next = ksts_pkg::ST_IDLE;
        end else begin
          state_next = ksts_pkg::ST_PAIR;
        end
      end
      default: state_next = ksts_pkg::ST_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    i_cnt_next        = i_cnt;
    j_cnt_next        = j_cnt;
    ahead_cnt_next    = ahead_cnt;
    pos_next          = pos;
    first_pos_next    = first_pos;
    rank_next         = rank;
    done_next         = 1'b0;
    answer_index_next = answer_index;
    query_error_next  = query_error;
    case (state)
      ksts_pkg::ST_IDLE: begin
        if (query_accept) begin
          if (query_bad) begin
            done_next         = 1'b1;
            answer_index_next = '0;
            query_error_next  = 1'b1;
          end else begin
            i_cnt_next     = '0;
            j_cnt_next     = '0;
            ahead_cnt_next = '0;
            rank_next      = rank_k;
            first_pos_next = ksts_pkg::LEN_W'(32'(used_len) - 32'(trim_length));
          end
        end
      end
      ksts_pkg::ST_PAIR: begin
        if (j_cnt != used_count) begin
          if (j_cnt == i_cnt) begin
            j_cnt_next = j_cnt + 1'b1;
          end else begin
            pos_next = first_pos;
          end
        end
      end
      ksts_pkg::ST_READ: begin
      end
      ksts_pkg::ST_CMP: begin
        if (digits_differ || last_digit) begin
          if (j_before_i) begin
            ahead_cnt_next = ahead_cnt + 1'b1;
          end
          j_cnt_next = j_cnt + 1'b1;
        end else begin
          pos_next = pos + 1'b1;
        end
      end
      ksts_pkg::ST_RANK: begin
        if (rank_hit) begin
          done_next         = 1'b1;
          answer_index_next = ksts_pkg::SIDX_W'(i_cnt);
          query_error_next  = 1'b0;
        end else if (last_string) begin
          done_next         = 1'b1;
          answer_index_next = '0;
          query_error_next  = 1'b1;
        end else begin
          i_cnt_next     = i_cnt + 1'b1;
          j_cnt_next     = '0;
          ahead_cnt_next = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ksts_pkg::ST_IDLE;
      done          <= 1'b0;
      string_count  <= ksts_pkg::SCOUNT_W'(1);
      string_length <= ksts_pkg::SLEN_W'(1);
    end else begin
      state <= state_next;
      done  <= done_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ksts_pkg::CFG_STRING_COUNT:  string_count  <= cfg_data[ksts_pkg::SCOUNT_W-1:0];
          ksts_pkg::CFG_STRING_LENGTH: string_length <= cfg_data[ksts_pkg::SLEN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    i_cnt        <= i_cnt_next;
    j_cnt        <= j_cnt_next;
    ahead_cnt    <= ahead_cnt_next;
    pos          <= pos_next;
    first_pos    <= first_pos_next;
    rank         <= rank_next;
    answer_index <= answer_index_next;
    query_error  <= query_error_next;
  end

`ifndef SYNTH
  // a result is only raised while the sequencer is idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while sequencer busy");

  // a failed query carries index zero
  a_err_index: assert property (@(posedge clk) disable iff (rst)
    (done && query_error) |-> (answer_index == '0))
    else $error("error result with non-zero index");

  // a load transfer never starts the sequencer
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req_type == ksts_pkg::REQ_LOAD)) |=> !busy)
    else $error("load left the block busy");

  // a valid query enters the scan: busy is raised and no result is given yet
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req_type == ksts_pkg::REQ_QUERY) && !query_bad) |=> (busy && !done))
    else $error("valid query did not enter the scan");
`endif

endmodule
